@@ rtl/swmm_pkg.sv @@
// shared types and constants for the sliding window max/min core
// no dependencies; used by swmm_ctrl, swmm_datapath and the top level
package swmm_pkg;

   localparam int WINDOW_MAX_DEF  = 1024;
   localparam int SAMPLE_BITS_DEF = 30;
   localparam int CFG_BITS        = 11;
   localparam int RESULT_BITS     = 30;
   localparam logic [CFG_BITS-1:0] WINDOW_RESET = 11'd1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_TAIL,
      ST_HEAD,
      ST_PUSH,
      ST_EMIT
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic accept;
      logic tail_step;
      logic head_step;
      logic push;
      logic load_rsp;
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic tail_busy;
      logic head_busy;
      logic res_due;
   } dp_status_type;

endpackage

@@ rtl/swmm_deque.sv @@
// one monotonic deque: ring memory of {position, value} with head and count
// standalone; instantiated twice by swmm_datapath
module swmm_deque #(
   parameter int DEPTH  = 1024,
   parameter int DATA_W = 41
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       clear,
   input  logic                       pop_tail,
   input  logic                       pop_head,
   input  logic                       push,
   input  logic [DATA_W-1:0]          push_data,
   output logic [$clog2(DEPTH+1)-1:0] count,
   output logic [DATA_W-1:0]          head_data,
   output logic [DATA_W-1:0]          tail_data
);

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH+1);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [IDX_W-1:0]  head_ff, head_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [DATA_W-1:0] head_rd_ff, tail_rd_ff;
   logic [IDX_W-1:0]  wr_addr, head_addr, tail_addr;
   logic [CNT_W-1:0]  tail_off;

   function automatic logic [IDX_W-1:0] ring(input logic [IDX_W-1:0] base,
                                              input logic [CNT_W-1:0] off);
      logic [CNT_W:0] sum;
      sum = (CNT_W+1)'(base) + (CNT_W+1)'(off);
      if (sum >= (CNT_W+1)'(DEPTH)) begin
         sum = sum - (CNT_W+1)'(DEPTH);
      end
      return sum[IDX_W-1:0];
   endfunction

   always_comb begin
      head_in  = head_ff;
      count_in = count_ff;
      priority if (clear) begin
         head_in  = '0;
         count_in = '0;
      end else if (pop_tail) begin
         count_in = count_ff - CNT_W'(1);
      end else if (pop_head) begin
         head_in  = ring(head_ff, CNT_W'(1));
         count_in = count_ff - CNT_W'(1);
      end else if (push) begin
         count_in = count_ff + CNT_W'(1);
      end
   end

   // read addresses follow the next pointers so the read registers match the new state
   assign wr_addr   = ring(head_ff, count_ff);
   assign tail_off  = (count_in == '0) ? '0 : count_in - CNT_W'(1);
   assign tail_addr = ring(head_in, tail_off);
   assign head_addr = head_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_addr] <= push_data;
      end
   end

   // write-through when the entry being written is read in the same cycle
   always_ff @(posedge clock) begin
      head_rd_ff <= (push && wr_addr == head_addr) ? push_data : mem_ff[head_addr];
      tail_rd_ff <= (push && wr_addr == tail_addr) ? push_data : mem_ff[tail_addr];
   end

   assign count     = count_ff;
   assign head_data = head_rd_ff;
   assign tail_data = tail_rd_ff;

endmodule

@@ rtl/swmm_datapath.sv @@
// datapath: window register, sample and position counters, both deques, result register
// depends on swmm_pkg and swmm_deque
module swmm_datapath #(
   parameter int WINDOW_MAX  = swmm_pkg::WINDOW_MAX_DEF,
   parameter int SAMPLE_BITS = swmm_pkg::SAMPLE_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  swmm_pkg::dp_cmd_type          cmd,
   output swmm_pkg::dp_status_type       status,
   input  logic [SAMPLE_BITS-1:0]        req_sample,
   input  logic                          req_first,
   input  logic                          csr_write,
   input  logic [swmm_pkg::CFG_BITS-1:0] csr_wdata,
   output logic [SAMPLE_BITS-1:0]        rsp_max,
   output logic [SAMPLE_BITS-1:0]        rsp_min
);

   localparam int CNT_W  = $clog2(WINDOW_MAX+1);
   localparam int POS_W  = $clog2(2*WINDOW_MAX);
   localparam int DATA_W = SAMPLE_BITS + POS_W;
   localparam logic [SAMPLE_BITS-1:0] RES_MASK = (SAMPLE_BITS > swmm_pkg::RESULT_BITS) ?
      SAMPLE_BITS'((65'(1) << swmm_pkg::RESULT_BITS) - 65'(1)) : {SAMPLE_BITS{1'b1}};

   logic [swmm_pkg::CFG_BITS-1:0] win_len_ff;
   logic [SAMPLE_BITS-1:0]        sample_ff;
   logic [POS_W-1:0]              pos_ff, pos_in;
   logic [CNT_W-1:0]              seen_ff, seen_in, seen_next;
   logic [CNT_W-1:0]              len_ff;
   logic [SAMPLE_BITS-1:0]        rsp_max_ff, rsp_min_ff;

   logic [31:0]       len_wide;
   logic              dq_clear;
   logic [CNT_W-1:0]  max_cnt, min_cnt;
   logic [DATA_W-1:0] max_head, max_tail, min_head, min_tail, push_data;
   logic              max_drop_t, min_drop_t, max_drop_h, min_drop_h;

   function automatic logic [POS_W-1:0] age(input logic [POS_W-1:0] cur,
                                             input logic [POS_W-1:0] hp);
      logic [POS_W:0] d;
      d = {1'b0, cur} - {1'b0, hp};
      if (d[POS_W]) begin
         d = d + (POS_W+1)'(2*WINDOW_MAX);
      end
      return d[POS_W-1:0];
   endfunction

   // zero counts as one, lengths above the bound saturate
   always_comb begin
      priority if (win_len_ff == '0) begin
         len_wide = 32'd1;
      end else if (32'(win_len_ff) > 32'(WINDOW_MAX)) begin
         len_wide = 32'(WINDOW_MAX);
      end else begin
         len_wide = 32'(win_len_ff);
      end
   end

   assign dq_clear  = cmd.accept & req_first;
   assign push_data = {pos_ff, sample_ff};
   assign seen_next = (seen_ff == CNT_W'(WINDOW_MAX)) ? seen_ff : seen_ff + CNT_W'(1);

   assign max_drop_t = (max_cnt != '0) && (max_tail[SAMPLE_BITS-1:0] < sample_ff);
   assign min_drop_t = (min_cnt != '0) && (min_tail[SAMPLE_BITS-1:0] > sample_ff);
   assign max_drop_h = (max_cnt != '0) &&
      (32'(age(pos_ff, max_head[DATA_W-1:SAMPLE_BITS])) >= 32'(len_ff));
   assign min_drop_h = (min_cnt != '0) &&
      (32'(age(pos_ff, min_head[DATA_W-1:SAMPLE_BITS])) >= 32'(len_ff));

   always_comb begin
      status.tail_busy = max_drop_t | min_drop_t;
      status.head_busy = max_drop_h | min_drop_h;
      status.res_due   = 32'(seen_next) >= 32'(len_ff);
   end

   always_comb begin
      pos_in  = pos_ff;
      seen_in = seen_ff;
      priority if (dq_clear) begin
         pos_in  = '0;
         seen_in = '0;
      end else if (cmd.push) begin
         pos_in  = (32'(pos_ff) == 32'(2*WINDOW_MAX-1)) ? '0 : pos_ff + POS_W'(1);
         seen_in = seen_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_len_ff <= swmm_pkg::WINDOW_RESET;
         pos_ff     <= '0;
         seen_ff    <= '0;
      end else begin
         if (csr_write) begin
            win_len_ff <= csr_wdata;
         end
         pos_ff  <= pos_in;
         seen_ff <= seen_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         sample_ff <= req_sample;
         len_ff    <= CNT_W'(len_wide);
      end
      if (cmd.load_rsp) begin
         rsp_max_ff <= max_head[SAMPLE_BITS-1:0] & RES_MASK;
         rsp_min_ff <= min_head[SAMPLE_BITS-1:0] & RES_MASK;
      end
   end

   swmm_deque #(
      .DEPTH  (WINDOW_MAX),
      .DATA_W (DATA_W)
   ) u_max_dq (
      .clock     (clock),
      .reset     (reset),
      .clear     (dq_clear),
      .pop_tail  (cmd.tail_step & max_drop_t),
      .pop_head  (cmd.head_step & max_drop_h),
      .push      (cmd.push),
      .push_data (push_data),
      .count     (max_cnt),
      .head_data (max_head),
      .tail_data (max_tail)
   );

   swmm_deque #(
      .DEPTH  (WINDOW_MAX),
      .DATA_W (DATA_W)
   ) u_min_dq (
      .clock     (clock),
      .reset     (reset),
      .clear     (dq_clear),
      .pop_tail  (cmd.tail_step & min_drop_t),
      .pop_head  (cmd.head_step & min_drop_h),
      .push      (cmd.push),
      .push_data (push_data),
      .count     (min_cnt),
      .head_data (min_head),
      .tail_data (min_tail)
   );

   assign rsp_max = rsp_max_ff;
   assign rsp_min = rsp_min_ff;

endmodule

@@ rtl/swmm_ctrl.sv @@
// controller: sequences tail pops, head pops, push and result load per request
// depends on swmm_pkg
module swmm_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output swmm_pkg::dp_cmd_type    cmd,
   input  swmm_pkg::dp_status_type status
);

   swmm_pkg::state_type state_ff, state_in;
   logic                rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= swmm_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      req_tready = 1'b0;
      cmd        = '0;
      unique case (state_ff)
         swmm_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               state_in   = swmm_pkg::ST_TAIL;
            end
         end
         swmm_pkg::ST_TAIL: begin
            cmd.tail_step = 1'b1;
            if (!status.tail_busy) begin
               state_in = swmm_pkg::ST_HEAD;
            end
         end
         swmm_pkg::ST_HEAD: begin
            cmd.head_step = 1'b1;
            if (!status.head_busy) begin
               state_in = swmm_pkg::ST_PUSH;
            end
         end
         swmm_pkg::ST_PUSH: begin
            cmd.push = 1'b1;
            state_in = status.res_due ? swmm_pkg::ST_EMIT : swmm_pkg::ST_IDLE;
         end
         swmm_pkg::ST_EMIT: begin
            // wait only while the output register still holds an untaken result
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.load_rsp = 1'b1;
               state_in     = swmm_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = swmm_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      priority if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

@@ rtl/sliding_window_max_min_core.sv @@
// top level of the sliding window maximum/minimum core
// depends on swmm_pkg, swmm_ctrl, swmm_datapath (and swmm_deque below it)
//
//   channel   ports                         moves
//   req       req_tvalid/tready/tdata/tuser one sample per request
//   rsp       rsp_tvalid/tready/tdata       window maximum and minimum
//   csr       csr_valid/ready/wdata         window length write
//
// a request steps through the accept, tail-pop, head-pop and push states, and the emit
// state when it gives a result; pops of both deques run side by side, one per cycle,
// bounded by the single read port pair of each deque memory
// every sample is popped at most once per deque
// reset clears pointers, counters and the window length (to 1); deque memories are not cleared
// the result sits in an output register; the next request is taken while it waits
module sliding_window_max_min_core #(
   parameter int WINDOW_MAX  = swmm_pkg::WINDOW_MAX_DEF,
   parameter int SAMPLE_BITS = swmm_pkg::SAMPLE_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // sample
   input  logic [((SAMPLE_BITS+7)/8)*8-1:0]      req_tdata,
   // first_sample
   input  logic                                  req_tuser,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // window_maximum, window_minimum
   output logic [((2*SAMPLE_BITS+7)/8)*8-1:0]    rsp_tdata,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [swmm_pkg::CFG_BITS-1:0]         csr_wdata
);

   localparam int RSP_W = ((2*SAMPLE_BITS+7)/8)*8;

   swmm_pkg::dp_cmd_type    cmd;
   swmm_pkg::dp_status_type status;
   logic [SAMPLE_BITS-1:0]  rsp_max, rsp_min;

   assign csr_ready = 1'b1;

   swmm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .status     (status)
   );

   swmm_datapath #(
      .WINDOW_MAX  (WINDOW_MAX),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_sample (req_tdata[SAMPLE_BITS-1:0]),
      .req_first  (req_tuser),
      .csr_write  (csr_valid),
      .csr_wdata  (csr_wdata),
      .rsp_max    (rsp_max),
      .rsp_min    (rsp_min)
   );

   assign rsp_tdata = RSP_W'({rsp_min, rsp_max});

endmodule
